/* rtl/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the sink accretion classifier.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int STEP_CNT_W    = 7;
  localparam int DIV_STEPS     = 64;
  localparam int SQRT_W        = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X        = 3'd0,
    REG_CENTER_Y        = 3'd1,
    REG_CENTER_Z        = 3'd2,
    REG_BOUNDARY_RADIUS = 3'd3,
    REG_FORCED_RADIUS   = 3'd4,
    REG_JMAX_PER_MASS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        boundary_radius;
    logic [31:0]        forced_radius;
    logic [31:0]        jmax_per_mass;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        mass;
    logic               last;
    logic               acc;
    logic [63:0]        dsq;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   pop;
    entry_t entry;
  } queue_rd_t;

endpackage

/* rtl/sac_ifs.sv */
// ----------------------------------------------------------------------------
// sac_ifs
// Channel interfaces: particle input, result output, register writes.
// ----------------------------------------------------------------------------
interface particle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [31:0]        particle_mass;
  logic               last_particle;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 particle_mass, last_particle, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               particle_mass, last_particle, output ready);
endinterface

interface result_if;
  logic               valid;
  logic               ready;
  logic               accreted;
  logic               pass_done;
  logic [47:0]        total_mass;
  logic signed [63:0] total_jx;
  logic signed [63:0] total_jy;
  logic signed [63:0] total_jz;
  logic [31:0]        new_radius;

  modport source(output valid, accreted, pass_done, total_mass, total_jx, total_jy,
                 total_jz, new_radius, input ready);
  modport sink(input valid, accreted, pass_done, total_mass, total_jx, total_jy,
               total_jz, new_radius, output ready);
endinterface

interface config_if import sac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/sac_sqrt.sv */
// ----------------------------------------------------------------------------
// sac_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sac_sqrt import sac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SQRT_W-1:0]     radicand,
  input  logic [STEP_CNT_W-1:0] iters,
  output logic                  done,
  output logic [63:0]           root
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] cnt;
  logic [SQRT_W-1:0]     rad;
  logic [66:0]           rem;
  logic [66:0]           remx;
  logic [66:0]           trial;

  assign remx  = {rem[64:0], rad[SQRT_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQRT_W-3:0], 2'b00};
      if (remx >= trial) begin
        rem  <= remx - trial;
        root <= {root[62:0], 1'b1};
      end else begin
        rem  <= remx;
        root <= {root[62:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/sac_div.sv */
// ----------------------------------------------------------------------------
// sac_div
// Bit-serial floor(num * cap / den) for cap < den, one num bit per cycle.
// ----------------------------------------------------------------------------
module sac_div import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] cap,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] q
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] cnt;
  logic [63:0]           m;
  logic [63:0]           capr;
  logic [63:0]           denr;
  logic [65:0]           rem;
  logic [65:0]           r2;
  logic [65:0]           d1;
  logic [65:0]           d2;

  assign r2 = {rem[64:0], 1'b0} + (m[63] ? {2'b00, capr} : 66'd0);
  assign d1 = {2'b00, denr};
  assign d2 = {1'b0, denr, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m    <= num;
      capr <= cap;
      denr <= den;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      m <= {m[62:0], 1'b0};
      if (r2 >= d2) begin
        rem <= r2 - d2;
        q   <= {q[62:0], 1'b0} + 64'd2;
      end else if (r2 >= d1) begin
        rem <= r2 - d1;
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= r2;
        q   <= {q[62:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/sac_front.sv */
// ----------------------------------------------------------------------------
// sac_front
// Accepts particles, forms distance squared and capture test, fills queue.
// ----------------------------------------------------------------------------
module sac_front import sac_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  particle_if.sink        particle,
  input  cfg_t            regs,
  output logic            push,
  output entry_t          push_entry,
  input  logic            push_ready
);

  localparam logic [63:0] EPS =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

  function automatic logic [32:0] abs_diff(input logic [31:0] p, input logic [31:0] c);
    logic signed [32:0] d;
    d = $signed({p[31], p}) - $signed({c[31], c});
    abs_diff = d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? '1 : s[63:0];
  endfunction

  logic        en;
  logic        v1, v2;
  entry_t      e1, e2;
  logic [32:0] mx, my, mz;
  logic [31:0] r1;
  logic [63:0] sqx, sqy, sqz, thr2;
  logic        satx, saty, satz;
  logic [63:0] dsq, thr;

  assign en             = !v2 || push_ready;
  assign particle.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= particle.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1.pos_x <= particle.pos_x;
      e1.pos_y <= particle.pos_y;
      e1.pos_z <= particle.pos_z;
      e1.vel_x <= particle.vel_x;
      e1.vel_y <= particle.vel_y;
      e1.vel_z <= particle.vel_z;
      e1.mass  <= particle.particle_mass;
      e1.last  <= particle.last_particle;
      e1.acc   <= 1'b0;
      e1.dsq   <= '0;
      mx <= abs_diff(particle.pos_x, regs.center_x);
      my <= abs_diff(particle.pos_y, regs.center_y);
      mz <= abs_diff(particle.pos_z, regs.center_z);
      r1 <= (regs.forced_radius != '0) ? regs.forced_radius : regs.boundary_radius;
      e2   <= e1;
      sqx  <= mx[31:0] * mx[31:0];
      sqy  <= my[31:0] * my[31:0];
      sqz  <= mz[31:0] * mz[31:0];
      satx <= mx[32];
      saty <= my[32];
      satz <= mz[32];
      thr2 <= r1 * r1;
    end
  end

  always_comb begin
    dsq = sat_add(sat_add(satx ? '1 : sqx, saty ? '1 : sqy), satz ? '1 : sqz);
    thr = (thr2 < EPS) ? EPS : thr2;
    push_entry     = e2;
    push_entry.dsq = dsq;
    push_entry.acc = dsq < thr;
  end

  assign push = v2;

endmodule

/* rtl/sac_queue.sv */
// ----------------------------------------------------------------------------
// sac_queue
// Short FIFO between the classifying front and the accretion back end.
// ----------------------------------------------------------------------------
module sac_queue import sac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  output logic      push_ready,
  output logic      rd_valid,
  output entry_t    rd_entry,
  input  logic      pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign push_ready = cnt != CNT_W'(QUEUE_DEPTH);
  assign rd_valid   = cnt != '0;
  assign rd_entry   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && rd_valid;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= next_ptr(wr_ptr);
      if (do_pop)  rd_ptr <= next_ptr(rd_ptr);
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

/* rtl/sac_back.sv */
// ----------------------------------------------------------------------------
// sac_back
// Accretion sequencer: sums, momentum capping, minimum distance, radius.
// ----------------------------------------------------------------------------
module sac_back import sac_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       q_pop,
  result_if.source   result
);

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [STEP_CNT_W-1:0] MIN_ITERS  = STEP_CNT_W'(32);
  localparam logic [STEP_CNT_W-1:0] NORM_ITERS = STEP_CNT_W'(64);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RAD   = 9'b000000010,
    ST_CROSS = 9'b000000100,
    ST_NORM  = 9'b000001000,
    ST_ROOT  = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_SCALE = 9'b001000000,
    ST_ACCUM = 9'b010000000,
    ST_OUT   = 9'b100000000
  } back_state_t;

  function automatic logic [32:0] sx(input logic [31:0] v);
    sx = {v[31], v};
  endfunction

  function automatic logic [32:0] zx(input logic [31:0] v);
    zx = {1'b0, v};
  endfunction

  function automatic logic [64:0] sign_mag(input logic [63:0] x, input logic [63:0] y);
    logic neg;
    neg = $signed(x) < $signed(y);
    sign_mag = {neg, neg ? y - x : x - y};
  endfunction

  function automatic logic [63:0] scale(input logic [95:0] p, input logic neg);
    logic [63:0] v;
    v = 64'(p >> FRAC_BITS);
    if ((p >> (64 + FRAC_BITS)) != '0) scale = neg ? S64_MIN : S64_MAX;
    else if (neg) scale = (v >= S64_MIN) ? S64_MIN : 64'(-v);
    else scale = (v > S64_MAX) ? S64_MAX : v;
  endfunction

  function automatic logic [63:0] sat_add_s(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) sat_add_s = a[63] ? S64_MIN : S64_MAX;
    else sat_add_s = r;
  endfunction

  back_state_t         state;
  logic [3:0]          stp;
  entry_t              w;
  logic [63:0]         x;
  logic [63:0]         mg [3];
  logic                ng [3];
  logic [127:0]        n2, n2_add, n2_next;
  logic [63:0]         plo;
  logic [95:0]         pf [3];
  logic [47:0]         mass_sum;
  logic [63:0]         sum_j [3];
  logic [63:0]         min_dsq;
  logic [31:0]         rad;
  logic [63:0]         cap;
  logic [48:0]         mass_add;
  logic [64:0]         sm;

  logic signed [32:0]  ma, mb;
  logic signed [65:0]  mul_full;
  logic [63:0]         prod;

  logic                  sq_start, sq_done;
  logic [SQRT_W-1:0]     sq_rad;
  logic [STEP_CNT_W-1:0] sq_iters;
  logic [63:0]           sq_root;
  logic                  dv_start;
  logic                  dv_done [3];
  logic [63:0]           dv_q [3];

  logic                out_valid, out_acc, out_last;
  logic [47:0]         out_mass;
  logic [63:0]         out_j [3];
  logic [31:0]         out_rad;
  logic                out_free;
  logic                kept_lower;

  assign cap      = 64'(regs.jmax_per_mass) << FRAC_BITS;
  assign out_free = !out_valid || result.ready;
  assign mass_add = {1'b0, mass_sum} + 49'(q_entry.mass);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign kept_lower = !q_entry.acc && (q_entry.dsq < min_dsq);
  assign sm       = sign_mag(x, prod);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_CROSS: begin
        case (stp)
          4'd0: begin ma = sx(w.pos_y); mb = sx(w.vel_z); end
          4'd1: begin ma = sx(w.pos_z); mb = sx(w.vel_y); end
          4'd2: begin ma = sx(w.pos_z); mb = sx(w.vel_x); end
          4'd3: begin ma = sx(w.pos_x); mb = sx(w.vel_z); end
          4'd4: begin ma = sx(w.pos_x); mb = sx(w.vel_y); end
          4'd5: begin ma = sx(w.pos_y); mb = sx(w.vel_x); end
          default: ;
        endcase
      end
      ST_NORM: begin
        case (stp)
          4'd0: begin ma = zx(mg[0][31:0]);  mb = zx(mg[0][31:0]);  end
          4'd1: begin ma = zx(mg[0][31:0]);  mb = zx(mg[0][63:32]); end
          4'd2: begin ma = zx(mg[0][63:32]); mb = zx(mg[0][63:32]); end
          4'd3: begin ma = zx(mg[1][31:0]);  mb = zx(mg[1][31:0]);  end
          4'd4: begin ma = zx(mg[1][31:0]);  mb = zx(mg[1][63:32]); end
          4'd5: begin ma = zx(mg[1][63:32]); mb = zx(mg[1][63:32]); end
          4'd6: begin ma = zx(mg[2][31:0]);  mb = zx(mg[2][31:0]);  end
          4'd7: begin ma = zx(mg[2][31:0]);  mb = zx(mg[2][63:32]); end
          4'd8: begin ma = zx(mg[2][63:32]); mb = zx(mg[2][63:32]); end
          default: ;
        endcase
      end
      ST_SCALE: begin
        case (stp)
          4'd0: begin ma = zx(w.mass); mb = zx(mg[0][31:0]);  end
          4'd1: begin ma = zx(w.mass); mb = zx(mg[0][63:32]); end
          4'd2: begin ma = zx(w.mass); mb = zx(mg[1][31:0]);  end
          4'd3: begin ma = zx(w.mass); mb = zx(mg[1][63:32]); end
          4'd4: begin ma = zx(w.mass); mb = zx(mg[2][31:0]);  end
          4'd5: begin ma = zx(w.mass); mb = zx(mg[2][63:32]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_full = ma * mb;

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_comb begin
    case (stp)
      4'd1, 4'd4, 4'd7: n2_add = {64'd0, prod};
      4'd2, 4'd5, 4'd8: n2_add = {31'd0, prod, 33'd0};
      4'd3, 4'd6, 4'd9: n2_add = {prod, 64'd0};
      default:          n2_add = '0;
    endcase
    n2_next = n2 + n2_add;
  end

  always_comb begin
    sq_start = 1'b0;
    sq_rad   = n2_next;
    sq_iters = NORM_ITERS;
    if (state == ST_IDLE) begin
      sq_rad   = {q_entry.dsq, 64'd0};
      sq_iters = MIN_ITERS;
      sq_start = q_valid && kept_lower && !(&q_entry.dsq);
    end else if (state == ST_NORM) begin
      sq_start = (stp == 4'd9) && (n2_next != '0);
    end
  end

  assign dv_start = (state == ST_ROOT) && sq_done && (sq_root > cap);

  sac_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .iters    (sq_iters),
    .done     (sq_done),
    .root     (sq_root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    sac_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (dv_start),
      .num   (mg[i]),
      .cap   (cap),
      .den   (sq_root),
      .done  (dv_done[i]),
      .q     (dv_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stp       <= '0;
      out_valid <= 1'b0;
      mass_sum  <= '0;
      sum_j[0]  <= '0;
      sum_j[1]  <= '0;
      sum_j[2]  <= '0;
      min_dsq   <= '1;
      rad       <= '1;
    end else begin
      if (result.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            w <= q_entry;
            if (q_entry.acc) begin
              mass_sum <= mass_add[48] ? '1 : mass_add[47:0];
              n2       <= '0;
              stp      <= '0;
              state    <= ST_CROSS;
            end else if (kept_lower) begin
              min_dsq <= q_entry.dsq;
              if (&q_entry.dsq) begin
                rad   <= '1;
                state <= ST_OUT;
              end else begin
                state <= ST_RAD;
              end
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_RAD: begin
          if (sq_done) begin
            rad   <= {1'b0, sq_root[31:1]};
            state <= ST_OUT;
          end
        end
        ST_CROSS: begin
          stp <= stp + 1'b1;
          case (stp)
            4'd1, 4'd3, 4'd5: x <= prod;
            4'd2: begin ng[0] <= sm[64]; mg[0] <= sm[63:0]; end
            4'd4: begin ng[1] <= sm[64]; mg[1] <= sm[63:0]; end
            4'd6: begin
              ng[2] <= sm[64];
              mg[2] <= sm[63:0];
              stp   <= '0;
              state <= ST_NORM;
            end
            default: ;
          endcase
        end
        ST_NORM: begin
          stp <= stp + 1'b1;
          n2  <= n2_next;
          if (stp == 4'd9) begin
            state <= (n2_next != '0) ? ST_ROOT : ST_OUT;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            stp   <= '0;
            state <= (sq_root > cap) ? ST_DIV : ST_SCALE;
          end
        end
        ST_DIV: begin
          if (dv_done[0]) begin
            mg[0] <= dv_q[0];
            mg[1] <= dv_q[1];
            mg[2] <= dv_q[2];
            stp   <= '0;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          stp <= stp + 1'b1;
          case (stp)
            4'd1, 4'd3, 4'd5: plo <= prod;
            4'd2: pf[0] <= {32'd0, plo} + {prod, 32'd0};
            4'd4: pf[1] <= {32'd0, plo} + {prod, 32'd0};
            4'd6: begin
              pf[2] <= {32'd0, plo} + {prod, 32'd0};
              state <= ST_ACCUM;
            end
            default: ;
          endcase
        end
        ST_ACCUM: begin
          sum_j[0] <= sat_add_s(sum_j[0], scale(pf[0], ng[0]));
          sum_j[1] <= sat_add_s(sum_j[1], scale(pf[1], ng[1]));
          sum_j[2] <= sat_add_s(sum_j[2], scale(pf[2], ng[2]));
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (w.last) begin
              mass_sum <= '0;
              sum_j[0] <= '0;
              sum_j[1] <= '0;
              sum_j[2] <= '0;
              min_dsq  <= '1;
              rad      <= '1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_acc  <= w.acc;
      out_last <= w.last;
      out_mass <= mass_sum;
      out_j[0] <= sum_j[0];
      out_j[1] <= sum_j[1];
      out_j[2] <= sum_j[2];
      out_rad  <= (rad < regs.boundary_radius) ? regs.boundary_radius : rad;
    end
  end

  assign result.valid      = out_valid;
  assign result.accreted   = out_acc;
  assign result.pass_done  = out_last;
  assign result.total_mass = out_mass;
  assign result.total_jx   = out_j[0];
  assign result.total_jy   = out_j[1];
  assign result.total_jz   = out_j[2];
  assign result.new_radius = out_rad;

endmodule

/* rtl/sink_accretion_classifier.sv */
// ----------------------------------------------------------------------------
// sink_accretion_classifier
// Classifies particles against a sink and accumulates accreted quantities.
// ----------------------------------------------------------------------------
// Channels: particle (valid/ready, Q16.16 position, velocity, mass, last flag)
// in, result (valid/ready, disposition, totals, new radius) out, and cfg
// (valid/ready, register index and data), always ready. The user must see that
// cfg is written only while idle; the block itself does not enforce this. A
// two-stage front pipeline forms distance squared and the capture test and
// feeds a two-entry queue; the back end sequences one particle at a time. A
// kept particle that does not lower the minimum goes straight to output; one
// that lowers it runs the 32-step square root of the minimum. An accreted
// particle runs the cross products, the 64-step square root of the momentum
// norm (straight to output at zero momentum), the bit-serial mul-divide when
// the cap applies, then mass scaling and accumulation. The output register
// lets the back end finish the next particle while a result waits; a stalled
// receiver fills the queue, then drops particle.ready. Reset restores
// register defaults, clears the sums and sets the minimum to all ones;
// totals also restart after each last particle's result.
// ----------------------------------------------------------------------------
module sink_accretion_classifier import sac_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  particle_if.sink    particle,
  result_if.source    result,
  config_if.sink      cfg
);

  cfg_t   regs;
  logic   push, push_ready;
  entry_t push_entry;
  queue_rd_t qrd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center_x        <= '0;
      regs.center_y        <= '0;
      regs.center_z        <= '0;
      regs.boundary_radius <= 32'd65536;
      regs.forced_radius   <= '0;
      regs.jmax_per_mass   <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CENTER_X:        regs.center_x        <= cfg.data;
        REG_CENTER_Y:        regs.center_y        <= cfg.data;
        REG_CENTER_Z:        regs.center_z        <= cfg.data;
        REG_BOUNDARY_RADIUS: regs.boundary_radius <= cfg.data;
        REG_FORCED_RADIUS:   regs.forced_radius   <= cfg.data;
        REG_JMAX_PER_MASS:   regs.jmax_per_mass   <= cfg.data;
        default: ;
      endcase
    end
  end

  sac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .particle   (particle),
    .regs       (regs),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  sac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .rd_valid   (qrd.valid),
    .rd_entry   (qrd.entry),
    .pop        (qrd.pop)
  );

  sac_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q_valid (qrd.valid),
    .q_entry (qrd.entry),
    .q_pop   (qrd.pop),
    .result  (result)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sink accretion classifier. Particles go in over a
// valid/ready channel with random gaps in some phases. The bench works out
// the expected totals and radius for each accepted particle in its own model,
// and compares every returned result with the oldest expected one, field by
// field. Register settings change between drained phases and include the
// extreme values. One long output stall is used to back up the input channel.
// ----------------------------------------------------------------------------
module tb;
  import sac_pkg::*;

  localparam int                   LIMIT_CYCLES = 1_500_000;
  localparam int                   N_PHASES     = 10;
  localparam int                   PHASE_ITEMS  = 155;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd6;
  localparam logic [63:0]          ONES64       = '1;
  localparam logic [63:0]          S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]          S64_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0]          CAPTURE_EPS  = 64'd4295;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [31:0]        mass;
    logic               last;
  } particle_t;

  typedef struct packed {
    logic        acc;
    logic        done;
    logic [47:0] mass;
    logic [63:0] jx, jy, jz;
    logic [31:0] radius;
  } outcome_t;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  particle_if pin();
  result_if   rout();
  config_if   cfgc();

  sink_accretion_classifier dut (
    .clk(clk), .rst(rst), .particle(pin), .result(rout), .cfg(cfgc)
  );

  // register copy
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [31:0]        bnd_r, frc_r, jmax;
  // running pass state
  logic [47:0]        acc_mass;
  logic [63:0]        acc_jx, acc_jy, acc_jz;
  logic [63:0]        nearest_dsq;

  particle_t pending[$];
  outcome_t  expected[$];
  int        n_taken = 0;
  int        n_errors = 0;
  int        cycles = 0;
  bit        idle_on;
  logic      hold;

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ONES64 : s[63:0];
  endfunction

  function automatic logic [63:0] add_sat_s(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] axis_sq(logic signed [31:0] p, logic signed [31:0] c);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = {p[31], p} - {c[31], c};
    m = d < 0 ? -d : d;
    if (m[32]) return ONES64;
    return {32'd0, m[31:0]} * {32'd0, m[31:0]};
  endfunction

  function automatic logic [63:0] cross_mag(logic signed [31:0] a, logic signed [31:0] b,
                                            logic signed [31:0] c, logic signed [31:0] d,
                                            output logic neg);
    logic signed [64:0] x, y, df;
    x = 65'(a) * 65'(b);
    y = 65'(c) * 65'(d);
    df = x - y;
    neg = df < 0;
    df = neg ? -df : df;
    return df[63:0];
  endfunction

  function automatic logic [63:0] mass_scale(logic [31:0] m, logic [63:0] mag, logic neg);
    logic [127:0] p;
    logic [63:0]  v;
    p = {96'd0, m} * {64'd0, mag};
    if (p[127:80] != 0) return neg ? S64_MIN : S64_MAX;
    v = p[79:16];
    if (neg) return v >= S64_MIN ? S64_MIN : -v;
    return v > S64_MAX ? S64_MAX : v;
  endfunction

  function automatic logic [31:0] capture_r();
    return frc_r != 0 ? frc_r : bnd_r;
  endfunction

  function automatic void clear_pass();
    acc_mass    = '0;
    acc_jx      = '0;
    acc_jy      = '0;
    acc_jz      = '0;
    nearest_dsq = ONES64;
  endfunction

  function automatic outcome_t classify(particle_t pt);
    outcome_t     o;
    logic [63:0]  thr, dsq, n, cap, half;
    logic [63:0]  mg[3];
    logic         ng[3];
    logic [127:0] n2;
    logic [48:0]  ms;
    thr = {32'd0, capture_r()} * {32'd0, capture_r()};
    if (thr < CAPTURE_EPS) thr = CAPTURE_EPS;
    dsq = add_sat_u(add_sat_u(axis_sq(pt.px, ctr_x), axis_sq(pt.py, ctr_y)),
                    axis_sq(pt.pz, ctr_z));
    o = '0;
    if (dsq >= thr) begin
      if (dsq < nearest_dsq) nearest_dsq = dsq;
    end else begin
      o.acc = 1;
      ms = {1'b0, acc_mass} + {17'd0, pt.mass};
      acc_mass = ms[48] ? '1 : ms[47:0];
      mg[0] = cross_mag(pt.py, pt.vz, pt.pz, pt.vy, ng[0]);
      mg[1] = cross_mag(pt.pz, pt.vx, pt.px, pt.vz, ng[1]);
      mg[2] = cross_mag(pt.px, pt.vy, pt.py, pt.vx, ng[2]);
      n2 = {64'd0, mg[0]} * {64'd0, mg[0]} + {64'd0, mg[1]} * {64'd0, mg[1]}
         + {64'd0, mg[2]} * {64'd0, mg[2]};
      if (n2 != 0) begin
        n = isqrt(n2);
        cap = {16'd0, jmax, 16'd0};
        if (n > cap)
          for (int i = 0; i < 3; i++)
            mg[i] = 64'(({64'd0, mg[i]} * {64'd0, cap}) / {64'd0, n});
        acc_jx = add_sat_s(acc_jx, mass_scale(pt.mass, mg[0], ng[0]));
        acc_jy = add_sat_s(acc_jy, mass_scale(pt.mass, mg[1], ng[1]));
        acc_jz = add_sat_s(acc_jz, mass_scale(pt.mass, mg[2], ng[2]));
      end
    end
    if (nearest_dsq == ONES64) half = 64'hFFFF_FFFF;
    else half = isqrt({64'd0, nearest_dsq}) >> 1;
    if (half < {32'd0, bnd_r}) half = {32'd0, bnd_r};
    o.done   = pt.last;
    o.mass   = acc_mass;
    o.jx     = acc_jx;
    o.jy     = acc_jy;
    o.jz     = acc_jz;
    o.radius = half[31:0];
    if (pt.last) clear_pass();
    return o;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near_offset(logic [31:0] lim);
    logic [31:0] m;
    m = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic particle_t make_particle();
    particle_t   p;
    logic [31:0] r;
    r = capture_r();
    p.vx = rand_word();
    p.vy = rand_word();
    p.vz = rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        p.px = ctr_x + near_offset(r >> 1);
        p.py = ctr_y + near_offset(r >> 1);
        p.pz = ctr_z + near_offset(r >> 1);
      end
      5, 6: begin
        p.px = ctr_x + r + near_offset(2);
        p.py = ctr_y;
        p.pz = ctr_z + near_offset(1);
      end
      7: begin
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
      end
      8: begin
        p.px = rand_word();
        p.py = rand_word();
        p.pz = rand_word();
      end
      default: begin
        p.px = ctr_x + near_offset(r << 2);
        p.py = ctr_y + near_offset(r << 2);
        p.pz = ctr_z + near_offset(r << 2);
      end
    endcase
    case ($urandom_range(0, 7))
      0:       p.mass = '0;
      1:       p.mass = '1;
      2:       p.mass = $urandom_range(0, 1 << 18);
      default: p.mass = $urandom;
    endcase
    p.last = $urandom_range(0, 19) == 0;
    return p;
  endfunction

  function automatic particle_t part(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                    logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                    logic [31:0] m, logic last);
    particle_t p;
    p = {px, py, pz, vx, vy, vz, m, last};
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfgc.valid <= 1;
    cfgc.index <= idx;
    cfgc.data  <= val;
    do @(posedge clk); while (!cfgc.ready);
    cfgc.valid <= 0;
    case (idx)
      REG_CENTER_X:        ctr_x = val;
      REG_CENTER_Y:        ctr_y = val;
      REG_CENTER_Z:        ctr_z = val;
      REG_BOUNDARY_RADIUS: bnd_r = val;
      REG_FORCED_RADIUS:   frc_r = val;
      REG_JMAX_PER_MASS:   jmax  = val;
      default: ;
    endcase
  endtask

  // sampled mid-cycle so the edge updates have settled
  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || pin.valid || expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'd65536;
      3:       return $urandom_range(1, 64);
      default: return $urandom_range(1 << 12, 1 << 22);
    endcase
  endfunction

  // sender
  int send_gap;
  always @(posedge clk) begin
    int g;
    if (rst) begin
      pin.valid <= 0;
      send_gap  <= 0;
      clear_pass();
    end else if (!(pin.valid && !pin.ready)) begin
      g = send_gap;
      if (pin.valid) begin
        expected.push_back(classify({pin.pos_x, pin.pos_y, pin.pos_z, pin.vel_x,
                                     pin.vel_y, pin.vel_z, pin.particle_mass,
                                     pin.last_particle}));
        n_taken++;
        g = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (g > 0) begin
        pin.valid <= 0;
        send_gap  <= g - 1;
      end else if (pending.size() != 0) begin
        particle_t p;
        p = pending.pop_front();
        pin.pos_x         <= p.px;
        pin.pos_y         <= p.py;
        pin.pos_z         <= p.pz;
        pin.vel_x         <= p.vx;
        pin.vel_y         <= p.vy;
        pin.vel_z         <= p.vz;
        pin.particle_mass <= p.mass;
        pin.last_particle <= p.last;
        pin.valid         <= 1;
        send_gap          <= 0;
      end else begin
        pin.valid <= 0;
      end
    end
  end

  // receiver and checker
  int recv_stall;
  always @(posedge clk) begin
    int       s;
    outcome_t got, want;
    if (rst) begin
      rout.ready <= 0;
      recv_stall <= 0;
    end else begin
      s = recv_stall;
      if (rout.valid && rout.ready) begin
        got = {rout.accreted, rout.pass_done, rout.total_mass, rout.total_jx,
               rout.total_jy, rout.total_jz, rout.new_radius};
        if (expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = expected.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch acc %b/%b done %b/%b mass %h/%h jx %h/%h jy %h/%h jz %h/%h rad %h/%h",
                       want.acc, got.acc, want.done, got.done, want.mass, got.mass,
                       want.jx, got.jx, want.jy, got.jy, want.jz, got.jz,
                       want.radius, got.radius);
          end
        end
        s = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (s > 0) begin
        rout.ready <= 0;
        recv_stall <= s - 1;
      end else begin
        rout.ready <= !hold;
        recv_stall <= 0;
      end
    end
  end

  // long output stall to back up the input
  initial begin
    hold = 0;
    wait (n_taken >= 400);
    @(posedge clk);
    hold <= 1;
    repeat (400) @(posedge clk);
    hold <= 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] j;
    idle_on    = 1;
    cfgc.valid = 0;
    cfgc.index = REG_CENTER_X;
    cfgc.data  = '0;
    ctr_x = '0; ctr_y = '0; ctr_z = '0;
    bnd_r = 32'd65536; frc_r = '0; jmax = '0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // reset defaults: capture radius 1.0, momentum capped to zero
    pending.push_back(part(0, 0, 0, 0, 0, 0, 32'd65536, 0));
    pending.push_back(part(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           '1, '1, '1, '1, 0));
    pending.push_back(part(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1, 0));
    pending.push_back(part(32'd65536, 0, 0, 0, 32'd65536, 0, 32'd65536, 0));
    pending.push_back(part(32'd65535, 0, 0, 0, 32'd65536, 0, 32'd65536, 0));
    pending.push_back(part(32'd1000, 32'd2000, 32'd3000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, '1, 0));
    pending.push_back(part(32'd300, 0, 0, 0, 32'd65536, 0, '0, 0));
    pending.push_back(part(32'd200000, 32'd5, 0, 0, 0, 0, 32'd7, 1));
    pending.push_back(part(0, 0, 0, 32'd9, 32'd9, 32'd9, 32'd65536, 0));
    drain();

    // momentum cap active, tiny capture radius below the epsilon floor
    write_reg(REG_JMAX_PER_MASS, 32'd3);
    write_reg(REG_FORCED_RADIUS, 32'd1);
    write_reg(REG_UNUSED, '1);
    pending.push_back(part(32'd10, 32'd10, 0, 32'd65536, 32'd5, 0, 32'd65536, 0));
    pending.push_back(part(32'd64, 0, 0, 0, 32'd65536, 0, 32'd65536, 0));
    pending.push_back(part(32'd66, 0, 0, 0, 32'd65536, 0, 32'd65536, 0));
    pending.push_back(part(32'hFFFF_FFF0, 32'd3, 32'd1, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, '1, 1));
    drain();

    // saturating totals: everything inside a huge boundary
    write_reg(REG_FORCED_RADIUS, '0);
    write_reg(REG_BOUNDARY_RADIUS, '1);
    write_reg(REG_JMAX_PER_MASS, '1);
    for (int i = 0; i < 6; i++)
      pending.push_back(part(32'h7FFF_0000, 32'h8000_1000, 32'd17, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, '1, i == 5));
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_CENTER_X, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 : rand_word());
      write_reg(REG_CENTER_Y, ph == 1 ? 32'h8000_0000 : rand_word());
      write_reg(REG_CENTER_Z, rand_word());
      write_reg(REG_BOUNDARY_RADIUS, pick_radius());
      write_reg(REG_FORCED_RADIUS, $urandom_range(0, 1) ? '0 : pick_radius());
      case ($urandom_range(0, 3))
        0:       j = '0;
        1:       j = '1;
        2:       j = $urandom_range(1, 1 << 10);
        default: j = $urandom;
      endcase
      write_reg(REG_JMAX_PER_MASS, j);
      idle_on = (ph % 3) != 0;
      for (int i = 0; i < PHASE_ITEMS; i++) pending.push_back(make_particle());
      drain();
    end

    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
